@@ rtl/gsc_pkg.sv @@
// shared types, constants and codes for the gear shift controller
// no dependencies; imported by every module of the block
`default_nettype none

package gsc_pkg;

  localparam int CountWidth = 32;
  localparam int NumGears   = 5;
  localparam int ProdWidth  = 28;

  typedef logic [2:0]            gear_t;
  typedef logic [11:0]           speed_t;
  typedef logic [15:0]           rpm_t;
  typedef logic [15:0]           cfg_data_t;
  typedef logic [2:0]            cfg_index_t;
  typedef logic [3:0]            stat_item_t;
  typedef logic [31:0]           stat_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [ProdWidth-1:0]  prod_t;

  localparam gear_t FirstGear = 3'd0;
  localparam gear_t TopGear   = 3'd4;
  localparam gear_t GearStep  = 3'd1;

  localparam rpm_t ShiftRpm    = 16'd1000;
  localparam rpm_t TopShiftRpm = 16'd2500;

  localparam speed_t SpeedMinReset = 12'hFFF;
  localparam rpm_t   RpmMinReset   = 16'hFFFF;

  // operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpRead   = 1'b1;

  // configuration register indexes
  localparam cfg_index_t CfgFactorOne   = 3'd0;
  localparam cfg_index_t CfgFactorTwo   = 3'd1;
  localparam cfg_index_t CfgFactorThree = 3'd2;
  localparam cfg_index_t CfgFactorFour  = 3'd3;
  localparam cfg_index_t CfgFactorFive  = 3'd4;
  localparam cfg_index_t CfgUpshift     = 3'd5;
  localparam cfg_index_t CfgDownshift   = 3'd6;
  localparam cfg_index_t CfgTopDownshift = 3'd7;

  localparam cfg_data_t FactorOneReset    = 16'd26855;
  localparam cfg_data_t FactorTwoReset    = 16'd18717;
  localparam cfg_data_t FactorThreeReset  = 16'd12930;
  localparam cfg_data_t FactorFourReset   = 16'd9042;
  localparam cfg_data_t FactorFiveReset   = 16'd7595;
  localparam cfg_data_t UpshiftReset      = 16'd2500;
  localparam cfg_data_t DownshiftReset    = 16'd700;
  localparam cfg_data_t TopDownshiftReset = 16'd2000;

  // statistic selectors
  localparam stat_item_t StatCountLast = 4'd4;
  localparam stat_item_t StatMinSpeed  = 4'd5;
  localparam stat_item_t StatMaxSpeed  = 4'd6;
  localparam stat_item_t StatMinRpm    = 4'd7;
  localparam stat_item_t StatMaxRpm    = 4'd8;

  typedef struct packed {
    logic   valid;
    gear_t  gear;
    gear_t  next_gear;
    speed_t speed;
    rpm_t   rpm;
  } stat_upd_t;

  typedef struct packed {
    gear_t next_gear;
    rpm_t  rpm;
    rpm_t  rpm_out;
    logic  shifted;
  } shift_res_t;

endpackage

`default_nettype wire

@@ rtl/gsc_shift.sv @@
// rpm computation and shift decision for one sample item
// depends on gsc_pkg
`default_nettype none

module gsc_shift (
  input  gsc_pkg::gear_t      gear,
  input  gsc_pkg::speed_t     speed,
  input  gsc_pkg::cfg_data_t  factor,
  input  gsc_pkg::cfg_data_t  upshift_rpm,
  input  gsc_pkg::cfg_data_t  downshift_rpm,
  input  gsc_pkg::cfg_data_t  top_downshift_rpm,
  output gsc_pkg::shift_res_t res
);
  import gsc_pkg::*;

  prod_t product;
  rpm_t  rpm;

  assign product = prod_t'(speed) * prod_t'(factor);
  assign rpm     = product[ProdWidth-1:ProdWidth-16];

  always_comb begin
    res.rpm       = rpm;
    res.rpm_out   = rpm;
    res.next_gear = gear;
    if (gear == TopGear) begin
      if (rpm <= top_downshift_rpm) begin
        res.next_gear = gear - GearStep;
        res.rpm_out   = TopShiftRpm;
      end
    end else if (rpm >= upshift_rpm) begin
      res.next_gear = gear + GearStep;
      res.rpm_out   = ShiftRpm;
    end else if (gear != FirstGear && rpm <= downshift_rpm) begin
      res.next_gear = gear - GearStep;
      res.rpm_out   = ShiftRpm;
    end
    res.shifted = (res.next_gear != gear);
  end

endmodule

`default_nettype wire

@@ rtl/gsc_stats.sv @@
// per-gear statistics: transition counters, speed and rpm extremes, read mux
// depends on gsc_pkg
`default_nettype none

module gsc_stats (
  input  logic                clk,
  input  logic                rst,
  input  gsc_pkg::stat_upd_t  upd,
  input  gsc_pkg::gear_t      rd_gear,
  input  gsc_pkg::stat_item_t rd_item,
  output gsc_pkg::stat_t      rd_value
);
  import gsc_pkg::*;

  count_t counts    [NumGears][NumGears];
  speed_t min_speed [NumGears];
  speed_t max_speed [NumGears];
  rpm_t   min_rpm   [NumGears];
  rpm_t   max_rpm   [NumGears];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < NumGears; f++) begin
        min_speed[f] <= SpeedMinReset;
        max_speed[f] <= '0;
        min_rpm[f]   <= RpmMinReset;
        max_rpm[f]   <= '0;
        for (int t = 0; t < NumGears; t++) begin
          counts[f][t] <= '0;
        end
      end
    end else if (upd.valid) begin
      for (int f = 0; f < NumGears; f++) begin
        if (upd.gear == gear_t'(f)) begin
          if (upd.speed < min_speed[f]) min_speed[f] <= upd.speed;
          if (upd.speed > max_speed[f]) max_speed[f] <= upd.speed;
          if (upd.rpm < min_rpm[f]) min_rpm[f] <= upd.rpm;
          if (upd.rpm > max_rpm[f]) max_rpm[f] <= upd.rpm;
          for (int t = 0; t < NumGears; t++) begin
            if (upd.next_gear == gear_t'(t)) begin
              counts[f][t] <= counts[f][t] + count_t'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    rd_value = '0;
    if (rd_gear <= TopGear) begin
      priority if (rd_item <= StatCountLast) begin
        rd_value = stat_t'(counts[rd_gear][rd_item[2:0]]);
      end else if (rd_item == StatMinSpeed) begin
        rd_value = stat_t'(min_speed[rd_gear]);
      end else if (rd_item == StatMaxSpeed) begin
        rd_value = stat_t'(max_speed[rd_gear]);
      end else if (rd_item == StatMinRpm) begin
        rd_value = stat_t'(min_rpm[rd_gear]);
      end else if (rd_item == StatMaxRpm) begin
        rd_value = stat_t'(max_rpm[rd_gear]);
      end else begin
        rd_value = '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/gear_shift_controller_with_stats_core.sv @@
// an accepted item goes to the input register, then to the result register once no stalled result is held
// throughput: one item per cycle while the output is not stalled; input accepted while a result waits
// the shift loop closes through the gear register, with the rpm multiply and compares between
// reset: gear to first, counters and maxima to zero, minima to all ones,
// configuration to defaults, both channels empty
// top level; depends on gsc_pkg, gsc_shift and gsc_stats
`default_nettype none

module gear_shift_controller_with_stats_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  gsc_pkg::cfg_index_t  cfg_index,
  input  gsc_pkg::cfg_data_t   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  gsc_pkg::speed_t      speed,
  input  gsc_pkg::gear_t       stat_gear,
  input  gsc_pkg::stat_item_t  stat_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsc_pkg::gear_t       gear,
  output gsc_pkg::rpm_t        reported_rpm,
  output logic                 shifted,
  output gsc_pkg::stat_t       stat_value
);
  import gsc_pkg::*;

  cfg_data_t factor [NumGears];
  cfg_data_t upshift_rpm;
  cfg_data_t downshift_rpm;
  cfg_data_t top_downshift_rpm;

  logic       in_reg_valid;
  logic       in_op;
  speed_t     in_speed;
  gear_t      in_stat_gear;
  stat_item_t in_stat_item;

  gear_t      cur_gear;
  logic       advance;
  logic       is_sample;
  shift_res_t sres;
  stat_upd_t  upd;
  stat_t      rd_value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      factor[0]         <= FactorOneReset;
      factor[1]         <= FactorTwoReset;
      factor[2]         <= FactorThreeReset;
      factor[3]         <= FactorFourReset;
      factor[4]         <= FactorFiveReset;
      upshift_rpm       <= UpshiftReset;
      downshift_rpm     <= DownshiftReset;
      top_downshift_rpm <= TopDownshiftReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgFactorOne:    factor[0]         <= cfg_data;
        CfgFactorTwo:    factor[1]         <= cfg_data;
        CfgFactorThree:  factor[2]         <= cfg_data;
        CfgFactorFour:   factor[3]         <= cfg_data;
        CfgFactorFive:   factor[4]         <= cfg_data;
        CfgUpshift:      upshift_rpm       <= cfg_data;
        CfgDownshift:    downshift_rpm     <= cfg_data;
        CfgTopDownshift: top_downshift_rpm <= cfg_data;
      endcase
    end
  end

  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_op        <= operation;
      in_speed     <= speed;
      in_stat_gear <= stat_gear;
      in_stat_item <= stat_item;
    end
  end

  assign is_sample = (in_op == OpSample);

  gsc_shift u_shift (
    .gear              (cur_gear),
    .speed             (in_speed),
    .factor            (factor[cur_gear]),
    .upshift_rpm       (upshift_rpm),
    .downshift_rpm     (downshift_rpm),
    .top_downshift_rpm (top_downshift_rpm),
    .res               (sres)
  );

  assign upd.valid     = advance && is_sample;
  assign upd.gear      = cur_gear;
  assign upd.next_gear = sres.next_gear;
  assign upd.speed     = in_speed;
  assign upd.rpm       = sres.rpm;

  gsc_stats u_stats (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .rd_gear  (in_stat_gear),
    .rd_item  (in_stat_item),
    .rd_value (rd_value)
  );

  // gear state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gear  <= FirstGear;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      if (is_sample) begin
        cur_gear <= sres.next_gear;
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      if (is_sample) begin
        gear         <= sres.next_gear;
        reported_rpm <= sres.rpm_out;
        shifted      <= sres.shifted;
        stat_value   <= '0;
      end else begin
        gear         <= cur_gear;
        reported_rpm <= '0;
        shifted      <= 1'b0;
        stat_value   <= rd_value;
      end
    end
  end

`ifndef SYNTHESIS
  a_gear_range: assert property (@(posedge clk) disable iff (rst)
    cur_gear <= TopGear)
    else $error("gear register out of range");

  a_shift_override: assert property (@(posedge clk) disable iff (rst)
    out_valid && shifted |-> (reported_rpm == ShiftRpm || reported_rpm == TopShiftRpm))
    else $error("shift without rpm override");

  a_shift_no_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && shifted |-> stat_value == '0)
    else $error("statistic on a shifting sample");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  a_gear_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> gear == cur_gear)
    else $error("reported gear differs from gear register");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for gear_shift_controller_with_stats_core
// directed table then random samples and reads, checked against a gear and statistics predictor
// depends on rtl/gsc_pkg.sv and the core rtl
`timescale 1ns / 1ps

module testbench;
  import gsc_pkg::*;

  typedef struct packed {
    gear_t gear;
    rpm_t  rpm;
    logic  shifted;
    stat_t stat;
  } gear_result_t;

  typedef struct packed {
    logic         op;
    speed_t       spd;
    gear_t        sg;
    stat_item_t   si;
    logic         typed;
    gear_result_t res;
  } table_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  cfg_index_t  cfg_index = '0;
  cfg_data_t   cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OpSample;
  speed_t      speed = '0;
  gear_t       stat_gear = '0;
  stat_item_t  stat_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gear_t       gear;
  rpm_t        reported_rpm;
  logic        shifted;
  stat_t       stat_value;

  // predictor state
  cfg_data_t   shadow_cfg [8];
  gear_t       cur_gear;
  count_t      trans_counts [NumGears*NumGears];
  speed_t      min_spd [NumGears];
  speed_t      max_spd [NumGears];
  rpm_t        min_rpm [NumGears];
  rpm_t        max_rpm [NumGears];

  gear_result_t expected_q [$];
  gear_result_t want;
  table_row_t   directed_rows [25];
  cfg_data_t [7:0] cfg_vals;
  int           errors = 0;
  int           stall_pct = 20;

  gear_shift_controller_with_stats_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .speed        (speed),
    .stat_gear    (stat_gear),
    .stat_item    (stat_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gear         (gear),
    .reported_rpm (reported_rpm),
    .shifted      (shifted),
    .stat_value   (stat_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL gear_shift_controller_with_stats_core");
    $finish;
  end

  task automatic clear_predictor();
    shadow_cfg[CfgFactorOne]    = FactorOneReset;
    shadow_cfg[CfgFactorTwo]    = FactorTwoReset;
    shadow_cfg[CfgFactorThree]  = FactorThreeReset;
    shadow_cfg[CfgFactorFour]   = FactorFourReset;
    shadow_cfg[CfgFactorFive]   = FactorFiveReset;
    shadow_cfg[CfgUpshift]      = UpshiftReset;
    shadow_cfg[CfgDownshift]    = DownshiftReset;
    shadow_cfg[CfgTopDownshift] = TopDownshiftReset;
    cur_gear = FirstGear;
    for (int i = 0; i < NumGears*NumGears; i++) trans_counts[i] = '0;
    for (int i = 0; i < NumGears; i++) begin
      min_spd[i] = SpeedMinReset;
      max_spd[i] = '0;
      min_rpm[i] = RpmMinReset;
      max_rpm[i] = '0;
    end
  endtask

  function automatic gear_result_t predict_step(input logic op, input speed_t spd,
                                                input gear_t sg, input stat_item_t si);
    gear_result_t r;
    prod_t        prod;
    rpm_t         rpm;
    gear_t        nxt;
    r = '0;
    if (op == OpRead) begin
      if (sg < NumGears) begin
        if (si <= StatCountLast) r.stat = stat_t'(trans_counts[sg*NumGears + si]);
        else if (si == StatMinSpeed) r.stat = stat_t'(min_spd[sg]);
        else if (si == StatMaxSpeed) r.stat = stat_t'(max_spd[sg]);
        else if (si == StatMinRpm) r.stat = stat_t'(min_rpm[sg]);
        else if (si == StatMaxRpm) r.stat = stat_t'(max_rpm[sg]);
      end
    end else begin
      prod = prod_t'(spd) * prod_t'(shadow_cfg[CfgFactorOne + cur_gear]);
      rpm = prod[ProdWidth-1:12];
      if (spd < min_spd[cur_gear]) min_spd[cur_gear] = spd;
      if (spd > max_spd[cur_gear]) max_spd[cur_gear] = spd;
      if (rpm < min_rpm[cur_gear]) min_rpm[cur_gear] = rpm;
      if (rpm > max_rpm[cur_gear]) max_rpm[cur_gear] = rpm;
      nxt = cur_gear;
      r.rpm = rpm;
      // upshift test wins over downshift in the middle gears
      if (cur_gear == TopGear) begin
        if (rpm <= shadow_cfg[CfgTopDownshift]) begin
          nxt = cur_gear - GearStep;
          r.rpm = TopShiftRpm;
        end
      end else if (rpm >= shadow_cfg[CfgUpshift]) begin
        nxt = cur_gear + GearStep;
        r.rpm = ShiftRpm;
      end else if (cur_gear != FirstGear && rpm <= shadow_cfg[CfgDownshift]) begin
        nxt = cur_gear - GearStep;
        r.rpm = ShiftRpm;
      end
      trans_counts[cur_gear*NumGears + nxt] = trans_counts[cur_gear*NumGears + nxt] + 1'b1;
      r.shifted = (nxt != cur_gear);
      cur_gear = nxt;
    end
    r.gear = cur_gear;
    return r;
  endfunction

  function automatic table_row_t mk_row(input logic op, input int spd, input int sg,
                                        input int si, input logic typed, input int g,
                                        input int rpm, input int sh, input longint stat);
    table_row_t t;
    t.op = op;
    t.spd = speed_t'(spd);
    t.sg = gear_t'(sg);
    t.si = stat_item_t'(si);
    t.typed = typed;
    t.res.gear = gear_t'(g);
    t.res.rpm = rpm_t'(rpm);
    t.res.shifted = sh[0];
    t.res.stat = stat_t'(stat);
    return t;
  endfunction

  task automatic send_item(input logic op, input speed_t spd, input gear_t sg,
                           input stat_item_t si, input logic typed,
                           input gear_result_t typed_res);
    gear_result_t r;
    logic         held;
    while ($urandom_range(99) < stall_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    speed     <= spd;
    stat_gear <= sg;
    stat_item <= si;
    // stall is settled mid-cycle and holds until the next edge
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    r = predict_step(op, spd, sg, si);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  task automatic random_items(input int n, input bit near_thresholds);
    logic       op;
    int         s;
    int         thr;
    gear_t      sg;
    stat_item_t si;
    for (int k = 0; k < n; k++) begin
      op = ($urandom_range(99) < 25) ? OpRead : OpSample;
      sg = ($urandom_range(9) < 9) ? gear_t'($urandom_range(4)) : gear_t'($urandom_range(7));
      si = ($urandom_range(9) < 9) ? stat_item_t'($urandom_range(8))
                                   : stat_item_t'($urandom_range(15));
      if (near_thresholds) begin
        // factor of 1.0 (16'h1000, 12 fraction bits) makes rpm equal to the raw speed
        if (cur_gear == TopGear) thr = shadow_cfg[CfgTopDownshift];
        else if ($urandom_range(1)) thr = shadow_cfg[CfgUpshift];
        else thr = shadow_cfg[CfgDownshift];
        s = thr + int'($urandom_range(6)) - 3;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
      end else begin
        case ($urandom_range(2))
          0: s = $urandom_range(4095);
          1: s = $urandom_range(255);
          default: s = $urandom_range(2000, 400);
        endcase
      end
      send_item(op, speed_t'(s), sg, si, 1'b0, '0);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input cfg_data_t [7:0] vals);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      shadow_cfg[i] = vals[i];
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual gear %0d rpm %0d stat %0d",
                 $time, gear, reported_rpm, stat_value);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (gear !== want.gear) begin
          $display("%0t: gear expected %0d actual %0d", $time, want.gear, gear);
          errors++;
        end
        if (reported_rpm !== want.rpm) begin
          $display("%0t: rpm expected %0d actual %0d", $time, want.rpm, reported_rpm);
          errors++;
        end
        if (shifted !== want.shifted) begin
          $display("%0t: shifted expected %0d actual %0d", $time, want.shifted, shifted);
          errors++;
        end
        if (stat_value !== want.stat) begin
          $display("%0t: stat expected %0d actual %0d", $time, want.stat, stat_value);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    clear_predictor();
    directed_rows = '{
      mk_row(OpRead,   0,    0, StatMinSpeed, 1'b1, 0, 0, 0, 4095),
      mk_row(OpRead,   0,    4, StatMaxRpm,   1'b1, 0, 0, 0, 0),
      mk_row(OpRead,   0,    2, StatMinRpm,   1'b1, 0, 0, 0, 65535),
      mk_row(OpRead,   0,    1, 2,            1'b1, 0, 0, 0, 0),
      mk_row(OpRead,   0,    7, 0,            1'b1, 0, 0, 0, 0),
      mk_row(OpRead,   0,    0, 15,           1'b1, 0, 0, 0, 0),
      mk_row(OpRead,   0,    4, 9,            1'b1, 0, 0, 0, 0),
      mk_row(OpSample, 0,    0, 0,            1'b1, 0, 0, 0, 0),
      mk_row(OpSample, 4095, 7, 15,           1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 4095, 0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 4095, 0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 4095, 0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 4095, 0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 16,   0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 1600, 0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 16,   0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 16,   0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 400,  0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 16,   0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 16,   0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpSample, 16,   0, 0,            1'b0, 0, 0, 0, 0),
      mk_row(OpRead,   0,    0, 1,            1'b0, 0, 0, 0, 0),
      mk_row(OpRead,   0,    4, 3,            1'b0, 0, 0, 0, 0),
      mk_row(OpRead,   0,    3, StatMaxSpeed, 1'b0, 0, 0, 0, 0),
      mk_row(OpRead,   0,    0, StatMinRpm,   1'b0, 0, 0, 0, 0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].spd, directed_rows[i].sg,
                directed_rows[i].si, directed_rows[i].typed, directed_rows[i].res);

    // long stretch with no idling on either side
    stall_pct = 0;
    random_items(150, 1'b0);
    stall_pct = 20;
    wait_idle();
    random_items(150, 1'b0);
    wait_idle();

    // unity factors so speeds land on and around each threshold
    repeat (2) begin
      cfg_vals = {8{16'h1000}};
      cfg_vals[CfgUpshift]      = cfg_data_t'($urandom_range(3000, 200));
      cfg_vals[CfgDownshift]    = cfg_data_t'($urandom_range(cfg_vals[CfgUpshift] + 200, 100));
      cfg_vals[CfgTopDownshift] = cfg_data_t'($urandom_range(3000, 100));
      load_config(cfg_vals);
      random_items(125, 1'b1);
      wait_idle();
    end

    // extremes: never upshift and downshift only at zero speed, then always shift
    cfg_vals = {8{16'hFFFF}};
    cfg_vals[CfgDownshift]    = '0;
    cfg_vals[CfgTopDownshift] = '0;
    load_config(cfg_vals);
    random_items(100, 1'b0);
    wait_idle();
    cfg_vals = {8{16'hFFFF}};
    cfg_vals[CfgFactorOne]   = '0;
    cfg_vals[CfgFactorTwo]   = '0;
    cfg_vals[CfgFactorThree] = '0;
    cfg_vals[CfgFactorFour]  = '0;
    cfg_vals[CfgFactorFive]  = '0;
    cfg_vals[CfgUpshift]     = '0;
    load_config(cfg_vals);
    random_items(100, 1'b0);
    wait_idle();

    repeat (3) begin
      for (int i = 0; i < 8; i++) cfg_vals[i] = cfg_data_t'($urandom_range(65535));
      load_config(cfg_vals);
      random_items(80, 1'b0);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS gear_shift_controller_with_stats_core");
    end else begin
      $display("FAIL gear_shift_controller_with_stats_core");
    end
    $finish;
  end

endmodule
